// ===== src/blinf_pkg.sv =====
// ============================================================================
// blinf_pkg
// Shared constants and types for the box light influence block.
// ============================================================================
`default_nettype none

package blinf_pkg;

   // Default coordinate format: signed Q15.8 in 24 bits.
   localparam int COORD_WIDTH_DEF     = 24;
   localparam int COORD_FRAC_BITS_DEF = 8;

   // Fixed register field widths.
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int INV_RADIUS_W = 32;
   localparam int LUM_W        = 17;
   localparam int INFL_W       = 17;

   // Luminosity saturates at 1.0 in Q0.16.
   localparam logic [LUM_W-1:0] LUM_MAX = LUM_W'(65536);

   // Register reset values.
   localparam logic [INV_RADIUS_W-1:0] INV_RADIUS_RST = INV_RADIUS_W'(65536);
   localparam logic [LUM_W-1:0]        LUM_RST        = LUM_W'(32768);

   // Register map.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LIGHT_POS_X  = 3'd0,
      CSR_LIGHT_POS_Y  = 3'd1,
      CSR_LIGHT_POS_Z  = 3'd2,
      CSR_INV_RADIUS   = 3'd3,
      CSR_LUMINOSITY   = 3'd4,
      CSR_VISIBLE      = 3'd5
   } csr_index_type;

endpackage

`default_nettype wire

// ===== src/blinf_front.sv =====
// ============================================================================
// blinf_front
// Box front end: light-to-center offsets, their squares and sum, and the
// largest box side, over three register stages.
// ============================================================================
`default_nettype none

module blinf_front
   import blinf_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic signed [COORD_WIDTH-1:0] box_min [3],
   input  wire logic signed [COORD_WIDTH-1:0] box_max [3],
   input  wire logic signed [COORD_WIDTH-1:0] light_pos [3],
   output logic                               out_valid,
   output logic [2*COORD_WIDTH+3:0]           out_radicand,
   output logic signed [COORD_WIDTH:0]        out_side
);

   localparam int W     = COORD_WIDTH;
   localparam int DIFF_W = W + 2;
   localparam int MAG_W  = W + 1;
   localparam int SQ_W   = 2 * W + 2;
   localparam int RAD_W  = 2 * W + 4;

   // Stage 1 registers: offset magnitudes and per-axis sizes.
   logic                     s1_vld_ff;
   logic [MAG_W-1:0]         mag_ff [3];
   logic [MAG_W-1:0]         mag_in [3];
   logic signed [W:0]        size_ff [3];
   logic signed [W:0]        size_in [3];

   // Stage 2 registers: squares and the largest side.
   logic                     s2_vld_ff;
   logic [SQ_W-1:0]          sq_ff [3];
   logic [SQ_W-1:0]          sq_in [3];
   logic signed [W:0]        side_ff;
   logic signed [W:0]        side_in;

   // Stage 3 registers: sum of squares.
   logic                     s3_vld_ff;
   logic [RAD_W-1:0]         rad_ff;
   logic [RAD_W-1:0]         rad_in;
   logic signed [W:0]        side2_ff;

   logic signed [DIFF_W-1:0] two_pos;
   logic signed [DIFF_W-1:0] pair_sum;
   logic signed [DIFF_W-1:0] offset;
   logic [DIFF_W-1:0]        neg_offset;

   // Offset 2*pos - (min + max) is the center distance in half units.
   always_comb begin
      two_pos    = '0;
      pair_sum   = '0;
      offset     = '0;
      neg_offset = '0;
      for (int a = 0; a < 3; a++) begin
         two_pos    = {light_pos[a][W-1], light_pos[a], 1'b0};
         pair_sum   = {{2{box_min[a][W-1]}}, box_min[a]}
                    + {{2{box_max[a][W-1]}}, box_max[a]};
         offset     = two_pos - pair_sum;
         neg_offset = DIFF_W'(-offset);
         mag_in[a]  = offset[DIFF_W-1] ? neg_offset[MAG_W-1:0] : offset[MAG_W-1:0];
         size_in[a] = {box_max[a][W-1], box_max[a]} - {box_min[a][W-1], box_min[a]};
      end
   end

   // Squares of the magnitudes and the largest side (first axis wins ties).
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sq_in[a] = mag_ff[a] * mag_ff[a];
      end
      side_in = size_ff[0];
      if (size_ff[1] > side_in) begin
         side_in = size_ff[1];
      end
      if (size_ff[2] > side_in) begin
         side_in = size_ff[2];
      end
   end

   // Sum of the three squares.
   assign rad_in = RAD_W'(sq_ff[0]) + RAD_W'(sq_ff[1]) + RAD_W'(sq_ff[2]);

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         mag_ff[a]  <= mag_in[a];
         size_ff[a] <= size_in[a];
         sq_ff[a]   <= sq_in[a];
      end
      side_ff  <= side_in;
      rad_ff   <= rad_in;
      side2_ff <= side_ff;
   end

   assign out_valid    = s3_vld_ff;
   assign out_radicand = rad_ff;
   assign out_side     = side2_ff;

endmodule

`default_nettype wire

// ===== src/blinf_sqrt.sv =====
// ============================================================================
// blinf_sqrt
// Pipelined floor square root, one result bit per stage, with a side tag
// that travels alongside each item.
// ============================================================================
`default_nettype none

module blinf_sqrt
   import blinf_pkg::*;
#(
   parameter int ROOT_W = COORD_WIDTH_DEF + 2,
   parameter int TAG_W  = COORD_WIDTH_DEF + 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [2*ROOT_W-1:0]   in_radicand,
   input  wire logic [TAG_W-1:0]      in_tag,
   output logic                       out_valid,
   output logic [ROOT_W-1:0]          out_root,
   output logic [TAG_W-1:0]           out_tag
);

   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 1;
   localparam int CALC_W = ROOT_W + 3;

   logic             vld_ff  [ROOT_W];
   logic [TAG_W-1:0] tag_ff  [ROOT_W];
   logic [RAD_W-1:0] rad_ff  [ROOT_W];
   logic [RAD_W-1:0] rad_in  [ROOT_W];
   logic [REM_W-1:0] rem_ff  [ROOT_W];
   logic [REM_W-1:0] rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];

   // Stage inputs: the first stage starts from the radicand, the others
   // from the stage before.
   logic [RAD_W-1:0]  src_rad  [ROOT_W];
   logic [REM_W-1:0]  src_rem  [ROOT_W];
   logic [ROOT_W-1:0] src_root [ROOT_W];

   logic [CALC_W-1:0] rem_shift;
   logic [CALC_W-1:0] trial;
   logic [CALC_W-1:0] rem_diff;
   logic              fits;

   always_comb begin
      src_rad[0]  = in_radicand;
      src_rem[0]  = '0;
      src_root[0] = '0;
      for (int k = 1; k < ROOT_W; k++) begin
         src_rad[k]  = rad_ff[k-1];
         src_rem[k]  = rem_ff[k-1];
         src_root[k] = root_ff[k-1];
      end
   end

   // Restoring root step in every stage: bring down two radicand bits and
   // try 4*root + 1 against the partial remainder.
   always_comb begin
      rem_shift = '0;
      trial     = '0;
      rem_diff  = '0;
      fits      = 1'b0;
      for (int k = 0; k < ROOT_W; k++) begin
         rem_shift  = {src_rem[k], src_rad[k][RAD_W-1 -: 2]};
         trial      = {1'b0, src_root[k], 2'b01};
         rem_diff   = rem_shift - trial;
         fits       = (rem_shift >= trial);
         rem_in[k]  = fits ? rem_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
         root_in[k] = {src_root[k][ROOT_W-2:0], fits};
         rad_in[k]  = {src_rad[k][RAD_W-3:0], 2'b00};
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROOT_W; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < ROOT_W; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      tag_ff[0] <= in_tag;
      for (int k = 1; k < ROOT_W; k++) begin
         tag_ff[k] <= tag_ff[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         rad_ff[k]  <= rad_in[k];
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

   // Every valid root goes back to a radicand that went through all the root stages.
   a_root_latency: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, ROOT_W))
      else $error("root valid without matching entry");

endmodule

`default_nettype wire

// ===== src/blinf_falloff.sv =====
// ============================================================================
// blinf_falloff
// Back end: approximate distance, linear falloff against the inverse radius
// and scaling by luminosity, over four register stages.
// ============================================================================
`default_nettype none

module blinf_falloff
   import blinf_pkg::*;
#(
   parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic [COORD_WIDTH+1:0]    in_dist,
   input  wire logic signed [COORD_WIDTH:0] in_side,
   input  wire logic [INV_RADIUS_W-1:0]   inverse_radius,
   input  wire logic [LUM_W-1:0]          light_luminosity,
   input  wire logic                      light_visible,
   output logic                           out_valid,
   output logic [INFL_W-1:0]              out_influence
);

   localparam int W        = COORD_WIDTH;
   localparam int F        = COORD_FRAC_BITS;
   localparam int DIFF_W   = W + 4;
   localparam int APPROX_W = W + 3;
   localparam int HALF_W   = INV_RADIUS_W / 2;
   localparam int PART_W   = APPROX_W + HALF_W;
   localparam int PROD_W   = APPROX_W + INV_RADIUS_W;
   localparam int SHIFT    = F + 17;
   localparam int FALL_W   = SHIFT + 1;
   localparam int SCALE_W  = LUM_W + FALL_W;
   localparam logic [PROD_W-1:0] ONE = PROD_W'(1) << SHIFT;

   logic                      a_vld_ff;
   logic [APPROX_W-1:0]       approx_ff;
   logic [APPROX_W-1:0]       approx_in;
   logic signed [DIFF_W-1:0]  gap;

   logic                      b_vld_ff;
   logic [PART_W-1:0]         part_lo_ff;
   logic [PART_W-1:0]         part_hi_ff;

   logic                      c_vld_ff;
   logic [PROD_W-1:0]         prod;
   logic [FALL_W-1:0]         falloff_ff;
   logic [FALL_W-1:0]         falloff_in;

   logic                      d_vld_ff;
   logic [LUM_W-1:0]          lum_sat;
   logic [SCALE_W-1:0]        scaled_ff;

   // Distance minus half side, clamped at zero; a negative side adds.
   always_comb begin
      gap       = DIFF_W'({2'b00, in_dist}) - {{3{in_side[W]}}, in_side};
      approx_in = gap[DIFF_W-1] ? '0 : gap[APPROX_W-1:0];
   end

   // Falloff is one minus the product, saturated to zero once it reaches one.
   always_comb begin
      prod       = {part_hi_ff[PART_W-1:0], {HALF_W{1'b0}}}
                 + PROD_W'(part_lo_ff);
      falloff_in = (prod >= ONE) ? '0 : FALL_W'(ONE - prod);
   end

   assign lum_sat = (light_luminosity > LUM_MAX) ? LUM_MAX : light_luminosity;

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   // Payload stages; the wide product is split into two half-width partials.
   always_ff @(posedge clock) begin
      approx_ff  <= approx_in;
      part_lo_ff <= approx_ff * inverse_radius[HALF_W-1:0];
      part_hi_ff <= approx_ff * inverse_radius[INV_RADIUS_W-1:HALF_W];
      falloff_ff <= falloff_in;
      scaled_ff  <= lum_sat * falloff_ff;
   end

   assign out_valid     = d_vld_ff;
   assign out_influence = light_visible ? scaled_ff[SHIFT +: INFL_W] : '0;

   // The falloff never exceeds one.
   a_falloff_range: assert property (@(posedge clock) disable iff (reset)
      c_vld_ff |-> (PROD_W'(falloff_ff) <= ONE))
      else $error("falloff above one");

endmodule

`default_nettype wire

// ===== src/box_light_influence_top.sv =====
// ============================================================================
// box_light_influence_top
// Influence of one point light on an axis-aligned box, fully pipelined.
// ============================================================================
//
//   Channel   Direction  Handshake               Payload
//   req_      in         start, busy             box_min_x/y/z, box_max_x/y/z
//   rsp_      out        rsp_valid strobe        rsp_influence
//   csr_      in         csr_valid, csr_ready    csr_index, csr_wdata
//
// One box is taken every cycle; busy stays low.
// The pipeline has three front stages, one stage per root bit in the square
// root pipeline, and four back-end stages.
// Reset clears all valid bits and loads the register defaults.
// Each result is shown for one cycle and the receiver cannot stall it.
//
`default_nettype none

module box_light_influence_top
   import blinf_pkg::*;
#(
   parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [COORD_WIDTH-1:0] req_box_min_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_box_min_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_box_min_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_box_max_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_box_max_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_box_max_z,
   output logic                               rsp_valid,
   output logic [INFL_W-1:0]                  rsp_influence,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int W       = COORD_WIDTH;
   localparam int ROOT_W  = W + 2;
   localparam int LATENCY = W + 9;

   // Configuration registers.
   logic signed [W-1:0]       light_pos_x_ff;
   logic signed [W-1:0]       light_pos_y_ff;
   logic signed [W-1:0]       light_pos_z_ff;
   logic [INV_RADIUS_W-1:0]   inverse_radius_ff;
   logic [LUM_W-1:0]          light_luminosity_ff;
   logic                      light_visible_ff;

   logic                      accept;
   logic signed [W-1:0]       box_min [3];
   logic signed [W-1:0]       box_max [3];
   logic signed [W-1:0]       light_pos [3];

   logic                      front_valid;
   logic [2*W+3:0]            front_radicand;
   logic signed [W:0]         front_side;

   logic                      root_valid;
   logic [ROOT_W-1:0]         root_dist;
   logic [W:0]                root_side;

   // The pipeline never stalls, so both channels are always open.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // Register file write decode; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         light_pos_x_ff      <= '0;
         light_pos_y_ff      <= '0;
         light_pos_z_ff      <= '0;
         inverse_radius_ff   <= INV_RADIUS_RST;
         light_luminosity_ff <= LUM_RST;
         light_visible_ff    <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_LIGHT_POS_X: begin
               light_pos_x_ff <= csr_wdata[W-1:0];
            end
            CSR_LIGHT_POS_Y: begin
               light_pos_y_ff <= csr_wdata[W-1:0];
            end
            CSR_LIGHT_POS_Z: begin
               light_pos_z_ff <= csr_wdata[W-1:0];
            end
            CSR_INV_RADIUS: begin
               inverse_radius_ff <= csr_wdata[INV_RADIUS_W-1:0];
            end
            CSR_LUMINOSITY: begin
               light_luminosity_ff <= csr_wdata[LUM_W-1:0];
            end
            CSR_VISIBLE: begin
               light_visible_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Per-axis views of the box and the light.
   assign box_min[0]   = req_box_min_x;
   assign box_min[1]   = req_box_min_y;
   assign box_min[2]   = req_box_min_z;
   assign box_max[0]   = req_box_max_x;
   assign box_max[1]   = req_box_max_y;
   assign box_max[2]   = req_box_max_z;
   assign light_pos[0] = light_pos_x_ff;
   assign light_pos[1] = light_pos_y_ff;
   assign light_pos[2] = light_pos_z_ff;

   // Offsets, squared distance and largest side.
   blinf_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .box_min      (box_min),
      .box_max      (box_max),
      .light_pos    (light_pos),
      .out_valid    (front_valid),
      .out_radicand (front_radicand),
      .out_side     (front_side)
   );

   // Euclidean distance; the largest side rides along as a tag.
   blinf_sqrt #(
      .ROOT_W (ROOT_W),
      .TAG_W  (W + 1)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (front_valid),
      .in_radicand (front_radicand),
      .in_tag      (front_side),
      .out_valid   (root_valid),
      .out_root    (root_dist),
      .out_tag     (root_side)
   );

   // Approximate distance, falloff and luminosity scaling.
   blinf_falloff #(
      .COORD_WIDTH     (COORD_WIDTH),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_falloff (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (root_valid),
      .in_dist          (root_dist),
      .in_side          (root_side),
      .inverse_radius   (inverse_radius_ff),
      .light_luminosity (light_luminosity_ff),
      .light_visible    (light_visible_ff),
      .out_valid        (rsp_valid),
      .out_influence    (rsp_influence)
   );

   // Every result goes back to a transfer that went through the whole pipeline.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without matching transfer");

   // A hidden light gives zero influence.
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !light_visible_ff) |-> (rsp_influence == '0))
      else $error("nonzero influence from hidden light");

   // Influence never exceeds full luminosity.
   a_infl_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_influence <= LUM_MAX))
      else $error("influence above one");

endmodule

`default_nettype wire

// ===== verif/tb_box_light_influence_top.sv =====
// ============================================================================
// tb_box_light_influence_top
// Self-checking testbench for the box light influence pipeline.
// ----------------------------------------------------------------------------
// Boxes go in through the start/busy command port, and register writes go
// through the csr_ valid/ready channel while the pipeline is empty. A
// predictor in this file computes the influence of every accepted box from
// its own copy of the registers. Every strobed result is compared with the
// oldest pending prediction. A short directed table runs first. Random
// phases follow, each with its own register setting and its own idle pattern.
// ============================================================================
`default_nettype none

module tb_box_light_influence_top;
   timeunit 1ns;
   timeprecision 1ps;

   import blinf_pkg::*;

   localparam int CW              = COORD_WIDTH_DEF;
   localparam int FALL_SHIFT      = COORD_FRAC_BITS_DEF + 17;
   localparam int LATENCY         = CW + 9;
   localparam int CLK_PERIOD      = 12;
   localparam int RUN_LIMIT_NS    = 4_000_000;
   localparam int MAX_GAP         = 14;
   localparam int RAND_PHASES     = 12;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int DIR_ROWS        = 11;
   localparam int PREDICTED       = -1;
   localparam int MAX_PRINTS      = 100;

   localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

   // Indexes past the register map; writes to them must have no effect.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_7 = 3'd7;

   // Corner index 0 is x, 1 is y, 2 is z.
   typedef struct packed {
      logic [2:0][CW-1:0] lo_corner;
      logic [2:0][CW-1:0] hi_corner;
   } box_type;

   typedef struct packed {
      logic [31:0]       seq;
      logic [INFL_W-1:0] value;
   } infl_expect_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic signed [CW-1:0]   req_box_min_x = '0;
   logic signed [CW-1:0]   req_box_min_y = '0;
   logic signed [CW-1:0]   req_box_min_z = '0;
   logic signed [CW-1:0]   req_box_max_x = '0;
   logic signed [CW-1:0]   req_box_max_y = '0;
   logic signed [CW-1:0]   req_box_max_z = '0;
   logic                   rsp_valid;
   logic [INFL_W-1:0]      rsp_influence;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor copy of the register file.
   logic [2:0][CW-1:0]      light_at;
   logic [INV_RADIUS_W-1:0] inv_radius_cfg;
   logic [LUM_W-1:0]        luminosity_cfg;
   logic                    visible_cfg;

   infl_expect_type expected_influence [$];
   int              item_count  = 0;
   int              error_count = 0;

   box_type dir_box    [DIR_ROWS];
   int      dir_expect [DIR_ROWS];

   box_light_influence_top uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_box_min_x (req_box_min_x),
      .req_box_min_y (req_box_min_y),
      .req_box_min_z (req_box_min_z),
      .req_box_max_x (req_box_max_x),
      .req_box_max_y (req_box_max_y),
      .req_box_max_z (req_box_max_z),
      .rsp_valid     (rsp_valid),
      .rsp_influence (rsp_influence),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Influence of the configured light on one box, in Q0.16.
   function automatic logic [INFL_W-1:0] predict_influence(input box_type b);
      longint       lo, hi, pos, offset, size, side;
      logic [63:0]  mag, root_len, trial, approx, falloff, lum, one, product;
      logic [127:0] sum_sq;
      int           axis, bit_pos;
      if (!visible_cfg) return '0;
      sum_sq = '0;
      side   = 0;
      // Offsets and sizes are kept in half units, so the center is exact.
      for (axis = 0; axis < 3; axis++) begin
         lo     = longint'($signed(b.lo_corner[axis]));
         hi     = longint'($signed(b.hi_corner[axis]));
         pos    = longint'($signed(light_at[axis]));
         offset = 2 * pos - (lo + hi);
         size   = hi - lo;
         mag    = (offset < 0) ? 64'(-offset) : 64'(offset);
         sum_sq = sum_sq + 128'(mag) * 128'(mag);
         if (axis == 0 || size > side) side = size;
      end
      // Truncated integer square root, one bit per step.
      root_len = '0;
      for (bit_pos = 36; bit_pos >= 0; bit_pos--) begin
         trial = root_len | (64'd1 << bit_pos);
         if (128'(trial) * 128'(trial) <= sum_sq) root_len = trial;
      end
      // An inverted box has a negative side, which pushes the light away.
      if (side < 0) approx = root_len + 64'(-side);
      else if (64'(side) >= root_len) approx = '0;
      else approx = root_len - 64'(side);
      // Linear falloff; a product at or above 1.0 saturates it to zero.
      one = 64'd1 << FALL_SHIFT;
      if (inv_radius_cfg == '0 || approx == '0) falloff = one;
      else if (approx > (one - 64'd1) / 64'(inv_radius_cfg)) falloff = '0;
      else falloff = one - approx * 64'(inv_radius_cfg);
      lum     = (luminosity_cfg > LUM_MAX) ? 64'(LUM_MAX) : 64'(luminosity_cfg);
      product = (lum * falloff) >> FALL_SHIFT;
      return product[INFL_W-1:0];
   endfunction

   // One of the coordinate extremes, zero, minus one, or a random value.
   function automatic logic [CW-1:0] extreme_coord();
      case ($urandom_range(0, 4))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return '0;
         3:       return '1;
         default: return CW'($urandom());
      endcase
   endfunction

   // Mostly boxes around the light with random sizes, plus noise.
   function automatic box_type random_box();
      box_type       b;
      logic [CW-1:0] swap;
      int            kind, axis, span, center, extent;
      kind = $urandom_range(0, 9);
      for (axis = 0; axis < 3; axis++) begin
         if (kind <= 5 || kind == 8) begin
            span   = 1 << $urandom_range(0, 22);
            center = int'($signed(light_at[axis])) + int'($urandom_range(0, 2 * span)) - span;
            extent = $urandom_range(0, span);
            b.lo_corner[axis] = CW'(center - extent);
            b.hi_corner[axis] = CW'(center + extent);
            // Inverted boxes: swap the corners on some axes.
            if (kind == 8 && $urandom_range(0, 1) == 1) begin
               swap              = b.lo_corner[axis];
               b.lo_corner[axis] = b.hi_corner[axis];
               b.hi_corner[axis] = swap;
            end
         end else if (kind <= 7) begin
            b.lo_corner[axis] = CW'($urandom());
            b.hi_corner[axis] = CW'($urandom());
         end else begin
            b.lo_corner[axis] = extreme_coord();
            b.hi_corner[axis] = extreme_coord();
         end
      end
      return b;
   endfunction

   function automatic int draw_gap(input logic burst);
      return burst ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic set_row(input int row, input int x0, input int y0, input int z0,
                          input int x1, input int y1, input int z1, input int expect_val);
      dir_box[row].lo_corner = {CW'(z0), CW'(y0), CW'(x0)};
      dir_box[row].hi_corner = {CW'(z1), CW'(y1), CW'(x1)};
      dir_expect[row]        = expect_val;
   endtask

   // Stop sending and wait until every pending result has arrived.
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (expected_influence.size() != 0) @(posedge clock);
   endtask

   // Send one box after an idle gap and record what it should produce.
   task automatic send_box(input box_type b, input int gap, input int typed_value);
      infl_expect_type entry;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start         <= 1'b1;
      req_box_min_x <= b.lo_corner[0];
      req_box_min_y <= b.lo_corner[1];
      req_box_min_z <= b.lo_corner[2];
      req_box_max_x <= b.hi_corner[0];
      req_box_max_y <= b.hi_corner[1];
      req_box_max_z <= b.hi_corner[2];
      do @(posedge clock); while (busy !== 1'b0);
      entry.seq   = item_count;
      entry.value = (typed_value == PREDICTED) ? predict_influence(b) : INFL_W'(typed_value);
      expected_influence.push_back(entry);
      item_count++;
   endtask

   task automatic replay_row(input int row);
      send_box(dir_box[row], draw_gap(1'b0), PREDICTED);
   endtask

   // Register write; the pipeline is emptied first so no box sees a change.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_LIGHT_POS_X: light_at[0]    = data[CW-1:0];
         CSR_LIGHT_POS_Y: light_at[1]    = data[CW-1:0];
         CSR_LIGHT_POS_Z: light_at[2]    = data[CW-1:0];
         CSR_INV_RADIUS:  inv_radius_cfg = data[INV_RADIUS_W-1:0];
         CSR_LUMINOSITY:  luminosity_cfg = data[LUM_W-1:0];
         CSR_VISIBLE:     visible_cfg    = data[0];
         default:         ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Register setting of one random phase; the early phases force extremes.
   task automatic configure_phase(input int phase);
      logic [CSR_DATA_W-1:0]   noise;
      logic [CW-1:0]           coord;
      logic [INV_RADIUS_W-1:0] inv;
      logic [LUM_W-1:0]        lum;
      logic                    vis;
      int                      axis;
      for (axis = 0; axis < 3; axis++) begin
         noise = $urandom();
         case (phase)
            0:       coord = COORD_MAX;
            1:       coord = COORD_MIN;
            default: coord = ($urandom_range(0, 1) == 1) ? CW'($urandom())
                                : CW'(int'($urandom_range(0, 8192)) - 4096);
         endcase
         write_register(CSR_INDEX_W'(CSR_LIGHT_POS_X + axis), {noise[CSR_DATA_W-1:CW], coord});
      end
      case (phase)
         2:       inv = '0;
         3:       inv = '1;
         default: begin
            case ($urandom_range(0, 3))
               0:       inv = $urandom_range(1, 4096);
               1:       inv = $urandom_range(4096, 1 << 20);
               2:       inv = $urandom();
               default: inv = INV_RADIUS_RST;
            endcase
         end
      endcase
      write_register(CSR_INV_RADIUS, inv);
      case (phase)
         4:       lum = '0;
         5:       lum = '1;
         6:       lum = LUM_MAX;
         default: lum = ($urandom_range(0, 3) == 0) ? LUM_W'($urandom())
                           : LUM_W'($urandom_range(0, 65536));
      endcase
      noise = $urandom();
      write_register(CSR_LUMINOSITY, {noise[CSR_DATA_W-1:LUM_W], lum});
      vis   = (phase == 7) ? 1'b0 : ($urandom_range(0, 9) != 0);
      noise = $urandom();
      write_register(CSR_VISIBLE, {noise[CSR_DATA_W-1:1], vis});
      if ($urandom_range(0, 3) == 0) begin
         write_register(($urandom_range(0, 1) == 1) ? CSR_SPARE_6 : CSR_SPARE_7, $urandom());
      end
   endtask

   // Result checker: each strobed transfer is matched to the oldest prediction.
   always @(posedge clock) begin : check_results
      infl_expect_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (expected_influence.size() == 0) begin
            report_mismatch($sformatf("unexpected influence %0d", rsp_influence));
         end else begin
            want = expected_influence.pop_front();
            if (rsp_influence !== want.value) begin
               report_mismatch($sformatf("box %0d influence got %0d want %0d",
                                         want.seq, rsp_influence, want.value));
            end
         end
      end
   end

   // Stimulus sequence.
   initial begin : stimulus
      int   row, axis, phase, item;
      logic burst;

      light_at       = '0;
      inv_radius_cfg = INV_RADIUS_RST;
      luminosity_cfg = LUM_RST;
      visible_cfg    = 1'b1;

      // Boxes whose influence is obvious under the reset register values.
      set_row(0, -256, -256, -256, 256, 256, 256, 32768);
      set_row(1, 0, 0, 0, 0, 0, 0, 32768);
      set_row(2, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 32768);
      set_row(3, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 0);
      set_row(4, -8388608, -8388608, -8388608, -8388608, -8388608, -8388608, 0);
      set_row(5, 8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 0);
      set_row(6, 256, 256, 256, -256, -256, -256, 0);
      set_row(7, 512, -256, -256, -512, 256, 256, 32768);
      set_row(8, 128, 0, 0, 128, 0, 0, PREDICTED);
      set_row(9, 100, -50, 0, 300, 50, 10, PREDICTED);
      set_row(10, -700, 20, -5, -600, 90, 5, PREDICTED);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIR_ROWS; row++) begin
         send_box(dir_box[row], draw_gap(1'b0), dir_expect[row]);
      end

      // A hidden light gives no influence.
      write_register(CSR_VISIBLE, '0);
      replay_row(0);
      replay_row(8);
      write_register(CSR_VISIBLE, 32'd1);

      // Zero inverse radius: no falloff at any distance.
      write_register(CSR_INV_RADIUS, '0);
      replay_row(3);
      replay_row(5);

      // Largest inverse radius: any nonzero distance overflows the product.
      write_register(CSR_INV_RADIUS, '1);
      replay_row(8);
      replay_row(1);
      write_register(CSR_INV_RADIUS, INV_RADIUS_RST);

      // Luminosity above full scale is clamped, full scale passes as is.
      write_register(CSR_LUMINOSITY, '1);
      replay_row(0);
      replay_row(8);
      write_register(CSR_LUMINOSITY, CSR_DATA_W'(LUM_MAX));
      replay_row(8);

      // Light at the corners of the coordinate range, box at the far corner.
      for (axis = 0; axis < 3; axis++) begin
         write_register(CSR_INDEX_W'(CSR_LIGHT_POS_X + axis), CSR_DATA_W'(COORD_MAX));
      end
      replay_row(4);
      for (axis = 0; axis < 3; axis++) begin
         write_register(CSR_INDEX_W'(CSR_LIGHT_POS_X + axis), CSR_DATA_W'(COORD_MIN));
      end
      replay_row(3);

      // Unmapped indexes must leave every register alone.
      write_register(CSR_SPARE_6, '1);
      write_register(CSR_SPARE_7, '1);
      replay_row(0);

      // Random phases; some send their boxes with no idle gap, apart from rare drains.
      for (phase = 0; phase < RAND_PHASES; phase++) begin
         configure_phase(phase);
         burst = ($urandom_range(0, 3) == 0);
         for (item = 0; item < ITEMS_PER_PHASE; item++) begin
            if ($urandom_range(0, 99) == 0) drain_results();
            send_box(random_box(), draw_gap(burst), PREDICTED);
         end
      end

      // Let stray results show up after the last expected one.
      drain_results();
      repeat (2 * LATENCY) @(posedge clock);
      if (error_count == 0) begin
         $display("box_light_influence_top verification clean");
      end else begin
         $display("box_light_influence_top verification failed");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("box_light_influence_top verification failed");
      $finish;
   end

endmodule

`default_nettype wire
